FILE: sv/mm_pkg.sv
`default_nettype none
package mm_pkg;

   // field widths fixed by the interface
   localparam int FUNC_W = 2;
   localparam int IDX_W  = 6;
   localparam int ELEM_W = 16;
   localparam int SUM_W  = 35;
   localparam int POS_W  = 3;
   localparam int DIM_W  = 4;
   localparam int CSR_W  = 2;

   // widest element storage the datapath supports
   localparam int WIDE_W = 32;

   // command codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD_LEFT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_RIGHT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMPUTE    = 2'd2;

   // configuration register indexes
   localparam logic [CSR_W-1:0] CSR_ROWS_M  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_INNER_K = 2'd1;
   localparam logic [CSR_W-1:0] CSR_COLS_N  = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic [IDX_W-1:0]         element_index;
      logic signed [ELEM_W-1:0] element_value;
   } mm_req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] product_value;
      logic [POS_W-1:0]        out_row;
      logic [POS_W-1:0]        out_col;
      logic                    last_flag;
   } mm_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic              wr_left;
      logic              wr_right;
      logic [IDX_W-1:0]  wr_addr;
      logic [ELEM_W-1:0] wr_value;
      logic              mac_valid;
      logic [IDX_W-1:0]  a_addr;
      logic [IDX_W-1:0]  b_addr;
      logic              mac_first;
      logic              mac_last;
      logic              mac_final;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
   } mm_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pipe_busy;
   } mm_status_type;

endpackage
`default_nettype wire

FILE: sv/matrix_multiply.sv
`default_nettype none
// fixed-point matrix multiply, C = A x B, A is rows_m by inner_k, B is inner_k by cols_n
// request channel: start with req_payload, transfer when start is high and busy is low
//   func load left / load right writes one Q8.8 element at a row-major index;
//   busy stays low so loads can stream one per cycle
//   func compute raises busy until its final result has been sent
// the dot products run on one shared multiply-accumulate unit, one step per cycle,
// fed by one read port on each element store; that loop sets the compute time
// result channel: rsp_valid strobes each Q19.16 sum for one cycle, row-major order,
//   each sum registered through the store read, product and accumulate stages after its last step;
//   last_flag marks the final element; the receiver cannot stall results
// config channel: csr_valid / csr_ready with csr_index and csr_data, ready always high,
//   index 0 rows_m, 1 inner_k, 2 cols_n; write only while busy is low
// reset: synchronous, clears control, dims go back to 8; stores are not cleared and
//   must be loaded before they are used
module matrix_multiply #(
   parameter int MAX_DIM    = 8,
   parameter int DATA_WIDTH = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   // request channel
   input  wire                          start,
   output logic                         busy,
   input  wire mm_pkg::mm_req_type      req_payload,
   // result channel
   output logic                         rsp_valid,
   output mm_pkg::mm_rsp_type           rsp_payload,
   // configuration channel
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire [mm_pkg::CSR_W-1:0]      csr_index,
   input  wire [mm_pkg::DIM_W-1:0]      csr_data
);

   mm_pkg::mm_cmd_type    cmd;
   mm_pkg::mm_status_type status;

   // config writes are taken every cycle
   assign csr_ready = 1'b1;

   // sequencer: register file, loop counters, store addresses
   mm_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .csr_valid   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status)
   );

   // element stores, multiply and accumulate pipeline, result register
   mm_datapath #(
      .MAX_DIM    (MAX_DIM),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

FILE: sv/mm_ctrl.sv
`default_nettype none
module mm_ctrl #(
   parameter int MAX_DIM = 8
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire mm_pkg::mm_req_type      req_payload,
   input  wire                          csr_valid,
   input  wire [mm_pkg::CSR_W-1:0]      csr_index,
   input  wire [mm_pkg::DIM_W-1:0]      csr_data,
   output mm_pkg::mm_cmd_type           cmd,
   input  wire mm_pkg::mm_status_type   status
);

   localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int IW    = mm_pkg::IDX_W;
   localparam int DW4   = mm_pkg::DIM_W;
   localparam int PW    = mm_pkg::POS_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]     state_ff, state_in;
   logic [CW-1:0]  row_ff, row_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [CW-1:0]  inner_ff, inner_in;
   logic [DW4-1:0] rows_m_ff, inner_k_ff, cols_n_ff;
   logic [DW4-1:0] m_eff, k_eff, n_eff;
   logic           accept, row_end, col_end, inner_end;

   function automatic logic [DW4-1:0] clamp_dim(input logic [DW4-1:0] d);
      logic [DW4-1:0] r;
      if (d == '0) r = DW4'(1);
      else if (d > DW4'(MAX_DIM)) r = DW4'(MAX_DIM);
      else r = d;
      return r;
   endfunction

   assign m_eff = clamp_dim(rows_m_ff);
   assign k_eff = clamp_dim(inner_k_ff);
   assign n_eff = clamp_dim(cols_n_ff);

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign row_end   = (DW4'(row_ff) == m_eff - DW4'(1));
   assign col_end   = (DW4'(col_ff) == n_eff - DW4'(1));
   assign inner_end = (DW4'(inner_ff) == k_eff - DW4'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m_ff  <= mm_pkg::DIM_RESET;
         inner_k_ff <= mm_pkg::DIM_RESET;
         cols_n_ff  <= mm_pkg::DIM_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            mm_pkg::CSR_ROWS_M:  rows_m_ff  <= csr_data;
            mm_pkg::CSR_INNER_K: inner_k_ff <= csr_data;
            mm_pkg::CSR_COLS_N:  cols_n_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      inner_in = inner_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_payload.func == mm_pkg::FUNC_COMPUTE) begin
               state_in = ST_RUN;
               row_in   = '0;
               col_in   = '0;
               inner_in = '0;
            end
         end
         ST_RUN: begin
            if (!inner_end) begin
               inner_in = inner_ff + CW'(1);
            end else begin
               inner_in = '0;
               if (!col_end) begin
                  col_in = col_ff + CW'(1);
               end else begin
                  col_in = '0;
                  if (!row_end) row_in = row_ff + CW'(1);
                  else begin
                     row_in   = '0;
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         inner_ff <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         inner_ff <= inner_in;
      end
   end

   always_comb begin
      logic in_range;
      in_range      = ({1'b0, req_payload.element_index} < (IW + 1)'(DEPTH));
      cmd.wr_left   = accept && in_range && req_payload.func == mm_pkg::FUNC_LOAD_LEFT;
      cmd.wr_right  = accept && in_range && req_payload.func == mm_pkg::FUNC_LOAD_RIGHT;
      cmd.wr_addr   = req_payload.element_index;
      cmd.wr_value  = req_payload.element_value;
      cmd.mac_valid = (state_ff == ST_RUN);
      cmd.a_addr    = IW'(row_ff) * IW'(k_eff) + IW'(inner_ff);
      cmd.b_addr    = IW'(inner_ff) * IW'(n_eff) + IW'(col_ff);
      cmd.mac_first = (inner_ff == '0);
      cmd.mac_last  = inner_end;
      cmd.mac_final = inner_end && col_end && row_end;
      cmd.row       = PW'(row_ff);
      cmd.col       = PW'(col_ff);
   end

endmodule
`default_nettype wire

FILE: sv/mm_datapath.sv
`default_nettype none
module mm_datapath #(
   parameter int MAX_DIM    = 8,
   parameter int DATA_WIDTH = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire mm_pkg::mm_cmd_type    cmd,
   output mm_pkg::mm_status_type      status,
   output logic                       rsp_valid,
   output mm_pkg::mm_rsp_type         rsp_payload
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = mm_pkg::SUM_W;
   localparam int PW    = mm_pkg::POS_W;
   localparam int XW    = mm_pkg::WIDE_W;
   localparam int EW    = (2 * DATA_WIDTH > SW) ? 2 * DATA_WIDTH : SW;

   logic [DATA_WIDTH-1:0] left_mem  [DEPTH];
   logic [DATA_WIDTH-1:0] right_mem [DEPTH];

   logic [XW-1:0]         wr_wide;
   logic [DATA_WIDTH-1:0] wr_data;

   // stage 1: store read
   logic                         v1_ff, first1_ff, last1_ff, final1_ff;
   logic [PW-1:0]                row1_ff, col1_ff;
   logic signed [DATA_WIDTH-1:0] rd_a_ff, rd_b_ff;
   // stage 2: product
   logic                         v2_ff, first2_ff, last2_ff, final2_ff;
   logic [PW-1:0]                row2_ff, col2_ff;
   logic signed [SW-1:0]         prod_ff;
   // stage 3: accumulate
   logic signed [SW-1:0]         acc_ff, mac_sum;
   logic                         rsp_valid_ff;
   mm_pkg::mm_rsp_type           rsp_ff;

   logic signed [2*DATA_WIDTH-1:0] prod;
   logic signed [EW-1:0]           prod_ext;

   // element is taken as its low bits, zero-filled when storage is wider
   assign wr_wide = {{(XW - mm_pkg::ELEM_W){1'b0}}, cmd.wr_value};
   assign wr_data = wr_wide[DATA_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (cmd.wr_left)  left_mem[cmd.wr_addr[AW-1:0]]  <= wr_data;
      if (cmd.wr_right) right_mem[cmd.wr_addr[AW-1:0]] <= wr_data;
      rd_a_ff <= left_mem[cmd.a_addr[AW-1:0]];
      rd_b_ff <= right_mem[cmd.b_addr[AW-1:0]];
   end

   assign prod     = rd_a_ff * rd_b_ff;
   assign prod_ext = EW'(prod);
   assign mac_sum  = first2_ff ? prod_ff : acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      first1_ff <= cmd.mac_first;
      last1_ff  <= cmd.mac_last;
      final1_ff <= cmd.mac_final;
      row1_ff   <= cmd.row;
      col1_ff   <= cmd.col;
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      final2_ff <= final1_ff;
      row2_ff   <= row1_ff;
      col2_ff   <= col1_ff;
      prod_ff   <= prod_ext[SW-1:0];
      if (v2_ff) acc_ff <= mac_sum;
      rsp_ff.product_value <= mac_sum;
      rsp_ff.out_row       <= row2_ff;
      rsp_ff.out_col       <= col2_ff;
      rsp_ff.last_flag     <= final2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= cmd.mac_valid;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff && last2_ff;
      end
   end

   assign status.pipe_busy = v1_ff || v2_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload      = rsp_ff;

endmodule
`default_nettype wire

FILE: sv/mm_checker.sv
`default_nettype none
module mm_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          start,
   input wire                          busy,
   input wire mm_pkg::mm_req_type      req_payload,
   input wire                          rsp_valid,
   input wire mm_pkg::mm_rsp_type      rsp_payload
);

   // results only come out of a running compute
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_payload.func == mm_pkg::FUNC_COMPUTE |=> busy)
      else $error("compute transfer did not raise busy");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_payload.func != mm_pkg::FUNC_COMPUTE |=> !busy)
      else $error("load transfer held the block busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last_flag |=> !rsp_valid && !busy)
      else $error("activity after final element");

   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> $past(rsp_valid && rsp_payload.last_flag))
      else $error("busy dropped without final element");

endmodule

bind matrix_multiply mm_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);
`default_nettype wire

FILE: verif/mm_result_checker.sv
`timescale 1ns / 100ps
module mm_result_checker #(
   parameter int MAX_DIM = 8
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire                          busy,
   input  wire mm_pkg::mm_req_type      req_payload,
   input  wire                          rsp_valid,
   input  wire mm_pkg::mm_rsp_type      rsp_payload,
   input  wire                          csr_valid,
   input  wire                          csr_ready,
   input  wire [mm_pkg::CSR_W-1:0]      csr_index,
   input  wire [mm_pkg::DIM_W-1:0]      csr_data,
   output int                           sums_awaited,
   output int                           fail_count
);
   import mm_pkg::*;

   localparam int PRINT_CAP = 100;

   logic signed [ELEM_W-1:0] left_mem [MAX_DIM*MAX_DIM];
   logic signed [ELEM_W-1:0] right_mem [MAX_DIM*MAX_DIM];
   logic [DIM_W-1:0] rows_m;
   logic [DIM_W-1:0] inner_k;
   logic [DIM_W-1:0] cols_n;
   mm_rsp_type awaited_sums [$];
   mm_rsp_type want;

   function automatic int dim_in_use(input logic [DIM_W-1:0] d);
      if (d == 0) return 1;
      if (d > MAX_DIM) return MAX_DIM;
      return int'(d);
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // every element of C in row-major order, exact sum wrapped to the field width
   function automatic void predict_products();
      int m, k, n, r, c, i;
      longint acc;
      mm_rsp_type sum_item;
      m = dim_in_use(rows_m);
      k = dim_in_use(inner_k);
      n = dim_in_use(cols_n);
      for (r = 0; r < m; r++) begin
         for (c = 0; c < n; c++) begin
            acc = 0;
            for (i = 0; i < k; i++)
               acc += longint'(left_mem[r*k+i]) * longint'(right_mem[i*n+c]);
            sum_item.product_value = acc[SUM_W-1:0];
            sum_item.out_row       = r[POS_W-1:0];
            sum_item.out_col       = c[POS_W-1:0];
            sum_item.last_flag     = (r == m - 1) && (c == n - 1);
            awaited_sums.push_back(sum_item);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rows_m  = DIM_RESET;
         inner_k = DIM_RESET;
         cols_n  = DIM_RESET;
         awaited_sums.delete();
         sums_awaited <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROWS_M:  rows_m  = csr_data;
               CSR_INNER_K: inner_k = csr_data;
               CSR_COLS_N:  cols_n  = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (awaited_sums.size() == 0) begin
               report_mismatch($sformatf("result with none expected, row %0d col %0d",
                  rsp_payload.out_row, rsp_payload.out_col));
            end else begin
               want = awaited_sums.pop_front();
               if (rsp_payload.product_value !== want.product_value)
                  report_mismatch($sformatf("product_value %0d, want %0d (row %0d col %0d)",
                     rsp_payload.product_value, want.product_value,
                     want.out_row, want.out_col));
               if (rsp_payload.out_row !== want.out_row)
                  report_mismatch($sformatf("out_row %0d, want %0d",
                     rsp_payload.out_row, want.out_row));
               if (rsp_payload.out_col !== want.out_col)
                  report_mismatch($sformatf("out_col %0d, want %0d",
                     rsp_payload.out_col, want.out_col));
               if (rsp_payload.last_flag !== want.last_flag)
                  report_mismatch($sformatf("last_flag %0b, want %0b (row %0d col %0d)",
                     rsp_payload.last_flag, want.last_flag, want.out_row, want.out_col));
            end
         end
         if (start && !busy) begin
            case (req_payload.func)
               FUNC_LOAD_LEFT:  left_mem[req_payload.element_index]  = req_payload.element_value;
               FUNC_LOAD_RIGHT: right_mem[req_payload.element_index] = req_payload.element_value;
               FUNC_COMPUTE:    predict_products();
               default: ;
            endcase
         end
         sums_awaited <= awaited_sums.size();
      end
   end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import mm_pkg::*;

   localparam int MAX_DIM       = 8;
   localparam int ITEM_GOAL     = 470;
   localparam int SETTLE_CYCLES = 6;
   localparam int DRAIN_CYCLES  = 20;
   localparam int LIMIT_CYCLES  = 1000000;

   // the one func code the block has no use for
   localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;

   localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
   localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;

   // operand fill styles
   localparam int FILL_RANDOM   = 0;
   localparam int FILL_ALL_MIN  = 3;
   localparam int FILL_MIN_MAX  = 4;
   localparam int FILL_SMALL    = 5;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // every input of the block starts at a known value
   logic              start       = 1'b0;
   mm_req_type        req_payload = '0;
   logic              csr_valid   = 1'b0;
   logic [CSR_W-1:0]  csr_index   = CSR_ROWS_M;
   logic [DIM_W-1:0]  csr_data    = DIM_RESET;

   logic       busy;
   logic       rsp_valid;
   mm_rsp_type rsp_payload;
   logic       csr_ready;

   int sums_awaited;
   int fail_count;
   int cycle_count = 0;

   // stimulus bookkeeping: shapes in force and which store entries hold data
   int         rows_m = DIM_RESET;
   int         inner_k = DIM_RESET;
   int         cols_n = DIM_RESET;
   bit [63:0]  left_set = '0;
   bit [63:0]  right_set = '0;
   int         items_sent = 0;
   int         idle_pct = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   matrix_multiply #(
      .MAX_DIM    (MAX_DIM),
      .DATA_WIDTH (ELEM_W)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // watches all three channels, predicts every sum and counts mismatches
   mm_result_checker #(
      .MAX_DIM (MAX_DIM)
   ) u_result_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .sums_awaited (sums_awaited),
      .fail_count   (fail_count)
   );

   // hard stop in case the block hangs or drops results
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // register value 0 acts as 1, anything above the grid size acts as the grid size
   function automatic int dim_in_use(input logic [DIM_W-1:0] d);
      if (d == 0) return 1;
      if (d > MAX_DIM) return MAX_DIM;
      return int'(d);
   endfunction

   // mostly small shapes, a few full size, some out of range values
   function automatic logic [DIM_W-1:0] pick_dim();
      int r;
      r = $urandom_range(99);
      if (r < 8)  return '0;
      if (r < 14) return DIM_W'($urandom_range(15, 9));
      if (r < 24) return DIM_W'(MAX_DIM);
      if (r < 34) return DIM_W'($urandom_range(7, 5));
      return DIM_W'($urandom_range(4, 1));
   endfunction

   function automatic logic signed [ELEM_W-1:0] pick_value(input int style, input bit is_left);
      logic signed [ELEM_W-1:0] v;
      case (style)
         FILL_ALL_MIN: v = ELEM_MIN;
         // most negative product sum: min times max everywhere
         FILL_MIN_MAX: v = is_left ? ELEM_MIN : ELEM_MAX;
         FILL_SMALL: begin
            v = ELEM_W'($urandom_range(512));
            v = v - 16'sd256;
         end
         default: v = ELEM_W'($urandom);
      endcase
      return v;
   endfunction

   // one request transfer; start stays high on return so a following item
   // can go out back to back, callers that pause lower it themselves
   task automatic push_item(input mm_req_type item);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_payload <= mm_req_type'($urandom);
         @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      if (item.func != FUNC_RESERVED) items_sent++;
   endtask

   task automatic load_element(input logic [FUNC_W-1:0] which, input int idx,
                               input logic signed [ELEM_W-1:0] value);
      mm_req_type item;
      item.func          = which;
      item.element_index = IDX_W'(idx);
      item.element_value = value;
      push_item(item);
      if (which == FUNC_LOAD_LEFT) left_set[idx] = 1'b1;
      else right_set[idx] = 1'b1;
   endtask

   // index and value are don't-care on a compute, so they get junk
   task automatic compute_once();
      mm_req_type item;
      item = mm_req_type'($urandom);
      item.func = FUNC_COMPUTE;
      push_item(item);
   endtask

   task automatic send_reserved();
      mm_req_type item;
      item = mm_req_type'($urandom);
      item.func = FUNC_RESERVED;
      push_item(item);
   endtask

   // sender holds off until no sum is outstanding and the block is idle
   task automatic wait_quiet();
      start <= 1'b0;
      do @(posedge clock); while (sums_awaited != 0 || busy);
   endtask

   // register writes only happen on an idle block
   task automatic write_dim(input logic [CSR_W-1:0] which, input logic [DIM_W-1:0] value);
      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_index <= which;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (which)
         CSR_ROWS_M:  rows_m  = dim_in_use(value);
         CSR_INNER_K: inner_k = dim_in_use(value);
         CSR_COLS_N:  cols_n  = dim_in_use(value);
         default: ;
      endcase
   endtask

   // load every operand the next compute reads: unwritten ones always,
   // already written ones half the time, in mixed left/right order,
   // with the odd ignored code and stray reload thrown in
   task automatic fill_operands(input int style);
      int left_len, right_len, j;
      bit left_first;
      left_len  = rows_m * inner_k;
      right_len = inner_k * cols_n;
      for (j = 0; j < left_len || j < right_len; j++) begin
         left_first = $urandom_range(1);
         if (!left_first && j < right_len && (!right_set[j] || $urandom_range(1)))
            load_element(FUNC_LOAD_RIGHT, j, pick_value(style, 1'b0));
         if (j < left_len && (!left_set[j] || $urandom_range(1)))
            load_element(FUNC_LOAD_LEFT, j, pick_value(style, 1'b1));
         if (left_first && j < right_len && (!right_set[j] || $urandom_range(1)))
            load_element(FUNC_LOAD_RIGHT, j, pick_value(style, 1'b0));
         if ($urandom_range(19) == 0) send_reserved();
         if ($urandom_range(19) == 0)
            load_element($urandom_range(1) ? FUNC_LOAD_LEFT : FUNC_LOAD_RIGHT,
                         $urandom_range(63), pick_value(FILL_RANDOM, 1'b1));
      end
   endtask

   // one well-formed pass: maybe reshape, maybe change idling, load, compute, sometimes twice
   task automatic run_sequence();
      logic [CSR_W-1:0] reg_sel;
      int r;
      if ($urandom_range(99) < 35) begin
         case ($urandom_range(2))
            0:       reg_sel = CSR_ROWS_M;
            1:       reg_sel = CSR_INNER_K;
            default: reg_sel = CSR_COLS_N;
         endcase
         write_dim(reg_sel, pick_dim());
      end
      if ($urandom_range(99) < 25) begin
         r = $urandom_range(2);
         idle_pct = (r == 0) ? 0 : (r == 1) ? 71 : 15;
      end
      fill_operands($urandom_range(FILL_SMALL));
      if ($urandom_range(9) == 0) wait_quiet();
      compute_once();
      // back to back compute on the same operands
      if ($urandom_range(4) == 0) compute_once();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 1x1x1 with the extreme values
      idle_pct = 0;
      write_dim(CSR_ROWS_M, 4'd1);
      write_dim(CSR_INNER_K, 4'd1);
      write_dim(CSR_COLS_N, 4'd1);
      load_element(FUNC_LOAD_LEFT, 0, ELEM_MIN);
      load_element(FUNC_LOAD_RIGHT, 0, ELEM_MIN);
      compute_once();
      load_element(FUNC_LOAD_LEFT, 0, ELEM_MAX);
      compute_once();
      // ignored code must not disturb the stores
      send_reserved();
      compute_once();

      // zero acts as one, fifteen acts as the grid size: a 1x8 by 8x1 product,
      // all minimum values give the largest possible sum
      write_dim(CSR_ROWS_M, 4'd0);
      write_dim(CSR_INNER_K, 4'd15);
      write_dim(CSR_COLS_N, 4'd0);
      for (int i = 0; i < MAX_DIM; i++) begin
         load_element(FUNC_LOAD_LEFT, i, ELEM_MIN);
         load_element(FUNC_LOAD_RIGHT, i, ELEM_MIN);
      end
      compute_once();

      // reshape and reuse what is already loaded
      write_dim(CSR_ROWS_M, 4'd2);
      write_dim(CSR_INNER_K, 4'd1);
      write_dim(CSR_COLS_N, 4'd3);
      compute_once();

      // random part
      while (items_sent < ITEM_GOAL) run_sequence();

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: files.f
sv/mm_pkg.sv
sv/mm_ctrl.sv
sv/mm_datapath.sv
sv/matrix_multiply.sv
sv/mm_checker.sv
verif/mm_result_checker.sv
verif/tb_top.sv
